>>> src/bmmd_pkg.sv
// ----------------------------------------------------------------------------
// Banked memory map decoder package
// Shared types and constants for the decoder and its top level.
// ----------------------------------------------------------------------------
package bmmd_pkg;

  localparam int unsigned RAM_DEPTH_DEF   = 65536;
  localparam int unsigned COLOR_DEPTH_DEF = 1024;

  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_LOAD  = 2'd2;

  localparam int unsigned BANK_LORAM  = 0;
  localparam int unsigned BANK_HIRAM  = 1;
  localparam int unsigned BANK_CHAREN = 2;

  localparam logic [7:0] BANK_RESET  = 8'h3F;
  localparam logic [7:0] RAM_BYTE0   = 8'h00;
  localparam logic [7:0] MEM_FILL    = 8'hFF;
  localparam logic [15:0] COLOR_BASE = 16'hD800;

  typedef enum logic [3:0] {
    TGT_RAM     = 4'd0,
    TGT_BASIC   = 4'd1,
    TGT_CHAR    = 4'd2,
    TGT_KERNAL  = 4'd3,
    TGT_COLOR   = 4'd4,
    TGT_VIDEO   = 4'd5,
    TGT_SOUND   = 4'd6,
    TGT_CIA1    = 4'd7,
    TGT_CIA2    = 4'd8,
    TGT_IO1     = 4'd9,
    TGT_IO2     = 4'd10,
    TGT_ROMLOAD = 4'd11
  } tgt_t;

  typedef enum logic [1:0] {
    RSEL_ZERO  = 2'd0,
    RSEL_RAM   = 2'd1,
    RSEL_ROM   = 2'd2,
    RSEL_COLOR = 2'd3
  } rsel_t;

  typedef struct packed {
    tgt_t        target;
    rsel_t       rsel;
    logic [11:0] io_offset;
    logic        dev_wr;
    logic        ram_we;
    logic        rom_we;
    logic        col_we;
  } dec_t;

endpackage

>>> src/bmmd_decode.sv
// ----------------------------------------------------------------------------
// Banked memory map decoder: address decode
// Steers one bus access by the banking bits to a store or an I/O device.
// ----------------------------------------------------------------------------
module bmmd_decode
  import bmmd_pkg::*;
(
  input  logic [1:0]  mode,
  input  logic [15:0] address,
  input  logic [7:0]  bank,
  output dec_t        dec
);

  logic in_basic;
  logic in_io;
  logic in_kernal;
  logic lo;
  logic hi;
  logic ch;
  tgt_t io_tgt;

  assign lo        = bank[BANK_LORAM];
  assign hi        = bank[BANK_HIRAM];
  assign ch        = bank[BANK_CHAREN];
  assign in_basic  = (address[15:13] == 3'b101);
  assign in_io     = (address[15:12] == 4'hD);
  assign in_kernal = (address[15:13] == 3'b111);

  always_comb begin
    if (address[11:8] == 4'hF) begin
      io_tgt = TGT_IO2;
    end else if (address[11:8] == 4'hE) begin
      io_tgt = TGT_IO1;
    end else if (address[11:8] == 4'hD) begin
      io_tgt = TGT_CIA2;
    end else if (address[11:8] == 4'hC) begin
      io_tgt = TGT_CIA1;
    end else if (address[11]) begin
      io_tgt = TGT_COLOR;
    end else if (address[10]) begin
      io_tgt = TGT_SOUND;
    end else begin
      io_tgt = TGT_VIDEO;
    end
  end

  always_comb begin
    dec = '0;
    dec.target = TGT_RAM;
    dec.rsel   = RSEL_ZERO;
    case (mode)
      MODE_READ: begin
        if (in_basic && lo && hi) begin
          dec.target = TGT_BASIC;
          dec.rsel   = RSEL_ROM;
        end else if (in_io && (lo || hi)) begin
          if (ch) begin
            dec.target = io_tgt;
            if (io_tgt == TGT_COLOR) begin
              dec.rsel = RSEL_COLOR;
            end else begin
              dec.io_offset = address[11:0];
            end
          end else begin
            dec.target = TGT_CHAR;
            dec.rsel   = RSEL_ROM;
          end
        end else if (in_kernal && hi) begin
          dec.target = TGT_KERNAL;
          dec.rsel   = RSEL_ROM;
        end else begin
          dec.rsel = RSEL_RAM;
        end
      end
      MODE_WRITE: begin
        if (in_io && (lo || hi) && ch) begin
          dec.target = io_tgt;
          if (io_tgt == TGT_COLOR) begin
            dec.col_we = 1'b1;
          end else begin
            dec.io_offset = address[11:0];
            dec.dev_wr    = (io_tgt != TGT_IO1) && (io_tgt != TGT_IO2);
          end
        end else begin
          dec.ram_we = 1'b1;
        end
      end
      MODE_LOAD: begin
        dec.target = TGT_ROMLOAD;
        dec.rom_we = 1'b1;
      end
      default: begin
        dec = '0;
      end
    endcase
  end

endmodule

>>> src/banked_memory_map_decoder.sv
// ----------------------------------------------------------------------------
// Banked memory map decoder
// Serves CPU bus accesses from main RAM, a ROM image and colour RAM under
// the banking bits held in RAM byte 1, and reports I/O device accesses.
// ----------------------------------------------------------------------------
// Latency: the result strobe rises in the cycle after an item is taken.
// Throughput: one item per cycle while busy is low; each item reads each store and writes at most one.
// Reset: synchronous; afterwards a fill pass presets every location of
// main RAM and the ROM image while busy is high.
// The receiver cannot stall: each result is shown for one cycle only.
module banked_memory_map_decoder
  import bmmd_pkg::*;
#(
  parameter int unsigned RAM_DEPTH   = RAM_DEPTH_DEF,
  parameter int unsigned COLOR_DEPTH = COLOR_DEPTH_DEF
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  output logic [7:0]  out_read_data,
  output logic [3:0]  out_target,
  output logic [11:0] out_io_offset,
  output logic        out_device_write,
  output logic [7:0]  out_device_data
);

  localparam int unsigned RAM_AW = $clog2(RAM_DEPTH);
  localparam int unsigned COL_AW = $clog2(COLOR_DEPTH);

  logic [7:0] main_ram   [RAM_DEPTH];
  logic [7:0] rom_image  [RAM_DEPTH];
  logic [7:0] colour_mem [COLOR_DEPTH];

  logic              fill_r;
  logic [RAM_AW-1:0] fill_cnt_r;
  logic [7:0]        bank_r;
  logic              out_valid_r;
  tgt_t              target_r;
  rsel_t             rsel_r;
  logic [11:0]       io_offset_r;
  logic              dev_wr_r;
  logic [7:0]        dev_data_r;
  logic [7:0]        ram_q_r;
  logic [7:0]        rom_q_r;
  logic [7:0]        col_q_r;

  dec_t              dec;
  logic              accept;
  logic [RAM_AW-1:0] mem_addr;
  logic [COL_AW-1:0] col_addr;
  logic [15:0]       col_diff;
  logic [7:0]        fill_byte;

  bmmd_decode u_decode (
    .mode    (in_mode),
    .address (in_address),
    .bank    (bank_r),
    .dec     (dec)
  );

  assign busy     = fill_r;
  assign accept   = start && !fill_r;
  assign mem_addr = in_address[RAM_AW-1:0];
  assign col_diff = in_address - COLOR_BASE;
  assign col_addr = col_diff[COL_AW-1:0];

  always_comb begin
    if (fill_cnt_r == RAM_AW'(0)) begin
      fill_byte = RAM_BYTE0;
    end else if (fill_cnt_r == RAM_AW'(1)) begin
      fill_byte = BANK_RESET;
    end else begin
      fill_byte = MEM_FILL;
    end
  end

  always_ff @(posedge clk) begin
    if (fill_r) begin
      main_ram[fill_cnt_r]  <= fill_byte;
      rom_image[fill_cnt_r] <= MEM_FILL;
    end else if (accept) begin
      if (dec.ram_we) begin
        main_ram[mem_addr] <= in_write_data;
      end
      if (dec.rom_we) begin
        rom_image[mem_addr] <= in_write_data;
      end
    end
    if (accept) begin
      ram_q_r <= main_ram[mem_addr];
      rom_q_r <= rom_image[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && dec.col_we) begin
      colour_mem[col_addr] <= in_write_data;
    end
    if (accept) begin
      col_q_r <= colour_mem[col_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= 1'b1;
      fill_cnt_r  <= '0;
      bank_r      <= BANK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (fill_r) begin
        fill_cnt_r <= fill_cnt_r + RAM_AW'(1);
        if (fill_cnt_r == {RAM_AW{1'b1}}) begin
          fill_r <= 1'b0;
        end
      end
      if (accept && dec.ram_we && (in_address == 16'd1)) begin
        bank_r <= in_write_data;
      end
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      target_r    <= dec.target;
      rsel_r      <= dec.rsel;
      io_offset_r <= dec.io_offset;
      dev_wr_r    <= dec.dev_wr;
      dev_data_r  <= dec.dev_wr ? in_write_data : 8'h00;
    end
  end

  always_comb begin
    case (rsel_r)
      RSEL_RAM:   out_read_data = ram_q_r;
      RSEL_ROM:   out_read_data = rom_q_r;
      RSEL_COLOR: out_read_data = col_q_r;
      default:    out_read_data = 8'h00;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_target       = target_r;
  assign out_io_offset    = io_offset_r;
  assign out_device_write = dev_wr_r;
  assign out_device_data  = dev_data_r;

`ifndef NO_ASSERTIONS
  a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy))
    else $error("result without a preceding item");

  a_no_item_during_fill: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !out_valid || !$past(busy))
    else $error("item taken during fill pass");

  a_device_write_target: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_device_write) |->
      (out_target == TGT_VIDEO || out_target == TGT_SOUND ||
       out_target == TGT_CIA1 || out_target == TGT_CIA2))
    else $error("device write to a non-device target");

  a_romload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_target == TGT_ROMLOAD) |->
      (out_read_data == 8'h00 && out_io_offset == 12'h000 && !out_device_write))
    else $error("ROM load result carries data");
`endif

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Banked memory map decoder testbench
// Drives read, write, ROM load and unused accesses through the start/busy
// handshake and checks every result strobe against a behavioural model of
// the banked memory map. The model keeps its own copies of main RAM, the ROM
// image and colour RAM, and follows the banking bits held in RAM byte 1.
// A short directed sequence covers each region and banking case. Bursts of
// random items with random gaps follow, weighted towards bank switches,
// ROM loads and the region boundaries.
// ----------------------------------------------------------------------------
import bmmd_pkg::*;

localparam logic [1:0]  MODE_UNUSED = 2'd3;
localparam logic [15:0] BASIC_LO    = 16'hA000;
localparam logic [15:0] BASIC_HI    = 16'hBFFF;
localparam logic [15:0] IO_LO       = 16'hD000;
localparam logic [15:0] IO_HI       = 16'hDFFF;
localparam logic [15:0] KERNAL_LO   = 16'hE000;
localparam logic [15:0] SOUND_BASE  = 16'hD400;
localparam logic [15:0] CIA1_BASE   = 16'hDC00;
localparam logic [15:0] CIA2_BASE   = 16'hDD00;
localparam logic [15:0] IO1_BASE    = 16'hDE00;
localparam logic [15:0] IO2_BASE    = 16'hDF00;

typedef struct {
  logic [1:0]  mode;
  logic [15:0] address;
  logic [7:0]  read_data;
  tgt_t        target;
  logic [11:0] io_offset;
  logic        device_write;
  logic [7:0]  device_data;
} bus_reply_t;

class bank_map_model;
  bit [7:0]   main_mem [RAM_DEPTH_DEF];
  bit [7:0]   rom_mem [RAM_DEPTH_DEF];
  bit [7:0]   color_mem [COLOR_DEPTH_DEF];
  bit         color_seen [COLOR_DEPTH_DEF];
  bus_reply_t expected_replies [$];
  int         errors;

  function new();
    foreach (main_mem[i]) begin
      main_mem[i] = MEM_FILL;
      rom_mem[i] = MEM_FILL;
    end
    main_mem[0] = RAM_BYTE0;
    main_mem[1] = BANK_RESET;
    errors = 0;
  endfunction

  function tgt_t io_unit(logic [15:0] a);
    if (a >= IO2_BASE) return TGT_IO2;
    if (a >= IO1_BASE) return TGT_IO1;
    if (a >= CIA2_BASE) return TGT_CIA2;
    if (a >= CIA1_BASE) return TGT_CIA1;
    if (a >= COLOR_BASE) return TGT_COLOR;
    if (a >= SOUND_BASE) return TGT_SOUND;
    return TGT_VIDEO;
  endfunction

  task report(string msg);
    $display("ERROR: %s", msg);
    errors++;
  endtask

  function void note_access(logic [1:0] m, logic [15:0] a, logic [7:0] d);
    bus_reply_t  r;
    logic [7:0]  bank;
    logic [15:0] coff;
    logic [15:0] ioff;
    logic [9:0]  cidx;
    bit          low_on;
    bit          high_on;
    bit          char_on;
    bit          io_win;
    bank = main_mem[1];
    low_on = bank[BANK_LORAM];
    high_on = bank[BANK_HIRAM];
    char_on = bank[BANK_CHAREN];
    coff = a - COLOR_BASE;
    cidx = coff[9:0];
    ioff = a - IO_LO;
    io_win = (a >= IO_LO) && (a <= IO_HI) && (low_on || high_on);
    r.mode = m;
    r.address = a;
    r.read_data = '0;
    r.target = TGT_RAM;
    r.io_offset = '0;
    r.device_write = 1'b0;
    r.device_data = '0;
    case (m)
      MODE_READ: begin
        if (a >= BASIC_LO && a <= BASIC_HI && low_on && high_on) begin
          r.target = TGT_BASIC;
          r.read_data = rom_mem[a];
        end else if (io_win && char_on) begin
          r.target = io_unit(a);
          if (r.target == TGT_COLOR) r.read_data = color_mem[cidx];
          else r.io_offset = ioff[11:0];
        end else if (io_win) begin
          r.target = TGT_CHAR;
          r.read_data = rom_mem[a];
        end else if (a >= KERNAL_LO && high_on) begin
          r.target = TGT_KERNAL;
          r.read_data = rom_mem[a];
        end else begin
          r.read_data = main_mem[a];
        end
      end
      MODE_WRITE: begin
        if (io_win && char_on) begin
          r.target = io_unit(a);
          if (r.target == TGT_COLOR) begin
            color_mem[cidx] = d;
            color_seen[cidx] = 1'b1;
          end else begin
            r.io_offset = ioff[11:0];
            if (r.target != TGT_IO1 && r.target != TGT_IO2) begin
              r.device_write = 1'b1;
              r.device_data = d;
            end
          end
        end else begin
          main_mem[a] = d;
        end
      end
      MODE_LOAD: begin
        rom_mem[a] = d;
        r.target = TGT_ROMLOAD;
      end
      default: ;
    endcase
    expected_replies.push_back(r);
  endfunction

  task check_reply(logic [7:0] rd, logic [3:0] tgt, logic [11:0] off, logic dw,
                   logic [7:0] dd);
    bus_reply_t e;
    if (expected_replies.size() == 0) begin
      report($sformatf("unexpected result: target %0d read_data %h", tgt, rd));
      return;
    end
    e = expected_replies.pop_front();
    if (rd !== e.read_data)
      report($sformatf("mode %0d addr %h: read_data %h, expected %h",
                       e.mode, e.address, rd, e.read_data));
    if (tgt !== e.target)
      report($sformatf("mode %0d addr %h: target %0d, expected %0d",
                       e.mode, e.address, tgt, e.target));
    if (off !== e.io_offset)
      report($sformatf("mode %0d addr %h: io_offset %h, expected %h",
                       e.mode, e.address, off, e.io_offset));
    if (dw !== e.device_write)
      report($sformatf("mode %0d addr %h: device_write %b, expected %b",
                       e.mode, e.address, dw, e.device_write));
    if (dd !== e.device_data)
      report($sformatf("mode %0d addr %h: device_data %h, expected %h",
                       e.mode, e.address, dd, e.device_data));
  endtask
endclass

module tb;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 1450;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [1:0]  in_mode = MODE_READ;
  logic [15:0] in_address = '0;
  logic [7:0]  in_write_data = '0;
  logic        busy;
  logic        out_valid;
  logic [7:0]  out_read_data;
  logic [3:0]  out_target;
  logic [11:0] out_io_offset;
  logic        out_device_write;
  logic [7:0]  out_device_data;

  int unsigned   cycle_count = 0;
  bank_map_model model = new();

  logic [15:0] boundary_addr [0:20] = '{
    16'h9FFF, 16'hA000, 16'hBFFF, 16'hC000, 16'hCFFF, 16'hD000, 16'hD3FF,
    16'hD400, 16'hD7FF, 16'hD800, 16'hDBFF, 16'hDC00, 16'hDCFF, 16'hDD00,
    16'hDDFF, 16'hDE00, 16'hDEFF, 16'hDF00, 16'hDFFF, 16'hE000, 16'hFFFF
  };

  logic [15:0] io_page [0:6] = '{
    IO_LO, SOUND_BASE, COLOR_BASE, CIA1_BASE, CIA2_BASE, IO1_BASE, IO2_BASE
  };

  banked_memory_map_decoder i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_address       (in_address),
    .in_write_data    (in_write_data),
    .out_valid        (out_valid),
    .out_read_data    (out_read_data),
    .out_target       (out_target),
    .out_io_offset    (out_io_offset),
    .out_device_write (out_device_write),
    .out_device_data  (out_device_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_n && out_valid === 1'b1)
      model.check_reply(out_read_data, out_target, out_io_offset, out_device_write,
                        out_device_data);
  end

  task automatic send_access(input logic [1:0] m, input logic [15:0] a,
                             input logic [7:0] d);
    start <= 1'b1;
    in_mode <= m;
    in_address <= a;
    in_write_data <= d;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    model.note_access(m, a, d);
  endtask

  task automatic idle(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (model.expected_replies.size() != 0);
  endtask

  function automatic logic [15:0] pick_address();
    case ($urandom_range(0, 6))
      0: return 16'($urandom_range(0, 31));
      1: return ($urandom_range(0, 1) != 0) ? BASIC_LO + 16'($urandom_range(0, 31))
                                             : BASIC_HI - 16'($urandom_range(0, 31));
      2: return io_page[3'($urandom_range(0, 6))] + 16'($urandom_range(0, 15));
      3: return COLOR_BASE + 16'($urandom_range(0, COLOR_DEPTH_DEF - 1));
      4: return ($urandom_range(0, 1) != 0) ? KERNAL_LO + 16'($urandom_range(0, 31))
                                             : 16'hFFFF - 16'($urandom_range(0, 31));
      5: return boundary_addr[5'($urandom_range(0, 20))];
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic pick_access(output logic [1:0] m, output logic [15:0] a,
                             output logic [7:0] d);
    logic [7:0] bank;
    int         sel;
    sel = $urandom_range(0, 99);
    d = 8'($urandom);
    a = pick_address();
    if (sel < 10) begin
      m = MODE_WRITE;
      a = 16'h0001;
    end else if (sel < 13) begin
      m = MODE_UNUSED;
    end else if (sel < 28) begin
      m = MODE_LOAD;
    end else if (sel < 62) begin
      m = MODE_WRITE;
    end else begin
      m = MODE_READ;
    end
    // A colour RAM entry that has never been written must not be read.
    bank = model.main_mem[1];
    if (m == MODE_READ && a >= COLOR_BASE && a < CIA1_BASE &&
        (bank[BANK_LORAM] || bank[BANK_HIRAM]) && bank[BANK_CHAREN] &&
        !model.color_seen[a[9:0]])
      m = MODE_WRITE;
  endtask

  initial begin
    int          sent;
    int          burst;
    int          gap;
    logic [1:0]  m;
    logic [15:0] a;
    logic [7:0]  d;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_access(MODE_READ, 16'h0000, 8'h00);
    send_access(MODE_READ, 16'h0001, 8'hFF);
    send_access(MODE_READ, BASIC_LO, 8'h00);
    send_access(MODE_LOAD, BASIC_LO, 8'h12);
    send_access(MODE_READ, BASIC_LO, 8'h00);
    send_access(MODE_WRITE, BASIC_LO, 8'h77);
    send_access(MODE_LOAD, IO_LO, 8'h34);
    send_access(MODE_READ, IO_LO, 8'hFF);
    send_access(MODE_READ, 16'hD7FF, 8'h00);
    send_access(MODE_WRITE, CIA1_BASE, 8'hA5);
    send_access(MODE_WRITE, 16'hDDFF, 8'h5A);
    send_access(MODE_WRITE, 16'hDE10, 8'hC3);
    send_access(MODE_READ, IO_HI, 8'h00);
    send_access(MODE_WRITE, COLOR_BASE, 8'h00);
    send_access(MODE_WRITE, 16'hDBFF, 8'hFF);
    send_access(MODE_READ, COLOR_BASE, 8'h00);
    send_access(MODE_READ, 16'hDBFF, 8'h00);
    send_access(MODE_LOAD, 16'hFFFF, 8'h56);
    send_access(MODE_READ, 16'hFFFF, 8'h00);
    send_access(MODE_UNUSED, 16'hFFFF, 8'hFF);
    send_access(MODE_WRITE, 16'h0001, 8'h3B);
    send_access(MODE_READ, IO_LO, 8'h00);
    send_access(MODE_WRITE, 16'h0001, 8'h38);
    send_access(MODE_READ, BASIC_LO, 8'h00);
    send_access(MODE_READ, 16'hFFFF, 8'h00);
    send_access(MODE_WRITE, 16'h0001, BANK_RESET);
    drain();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
      for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        pick_access(m, a, d);
        send_access(m, a, d);
        if (m != MODE_UNUSED) sent++;
      end
      if ($urandom_range(0, 19) == 0) begin
        drain();
      end else begin
        gap = $urandom_range(0, 12);
        if (gap > 0) idle(gap);
      end
    end
    drain();
    repeat (10) @(posedge clk);

    if (model.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> sim.f
src/bmmd_pkg.sv
src/bmmd_decode.sv
src/banked_memory_map_decoder.sv
verif/tb.sv
